>>> src/bea_pkg.sv
// Package with shared constants, register indexes and payload types of the button block.
package bea_pkg;

  // Number of button lanes; lanes at or above sixteen do not exist.
  localparam int Buttons = 16;
  localparam int NumLanes = (Buttons > 16) ? 16 : Buttons;
  localparam logic [15:0] LaneMask =
    (NumLanes >= 16) ? 16'hFFFF : 16'((32'd1 << NumLanes) - 32'd1);

  localparam int TimerW = 16;
  localparam int FrameW = 10;
  localparam int CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegButtonEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFirstDelay   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRepeatStep   = 2'd2;

  // Register reset values.
  localparam logic [15:0] ButtonEnableRst = 16'hFFFF;
  localparam logic [15:0] FirstDelayRst   = 16'd500;
  localparam logic [15:0] RepeatStepRst   = 16'd50;

  typedef struct packed {
    logic [15:0]       buttons;
    logic [FrameW-1:0] frame_ms;
  } in_word_t;

  typedef struct packed {
    logic [15:0] held;
    logic [15:0] press_edge;
    logic [15:0] release_edge;
    logic [15:0] fire;
  } out_word_t;

  // Timing settings that every lane sees.
  typedef struct packed {
    logic [TimerW-1:0] first_delay;
    logic [TimerW-1:0] repeat_step;
  } timing_cfg_t;

endpackage

>>> src/bea_lane.sv
// One button lane: hold timer register with repeat detection.
module bea_lane (
  input  logic                        clk_i,
  input  logic                        advance_i,
  input  logic                        level_i,
  input  logic                        press_i,
  input  logic [bea_pkg::FrameW-1:0]  frame_ms_i,
  input  bea_pkg::timing_cfg_t        cfg_i,
  output logic                        fire_o
);

  logic [bea_pkg::TimerW-1:0] timer_q, timer_d;
  logic [bea_pkg::TimerW:0]   sum;
  logic [bea_pkg::TimerW-1:0] grown;
  logic [bea_pkg::TimerW-1:0] stepped;
  logic                       repeat_hit;

  // Grow the timer by the frame time, saturating at its maximum.
  always_comb begin
    sum = {1'b0, timer_q} + (bea_pkg::TimerW+1)'(frame_ms_i);
    grown = sum[bea_pkg::TimerW] ? {bea_pkg::TimerW{1'b1}} : sum[bea_pkg::TimerW-1:0];
    repeat_hit = (grown >= cfg_i.first_delay);
    stepped = (grown >= cfg_i.repeat_step) ? (grown - cfg_i.repeat_step) : '0;
  end

  // A press clears the timer; a repeat takes the step off it.
  always_comb begin
    if (press_i) begin
      timer_d = '0;
    end else if (repeat_hit) begin
      timer_d = stepped;
    end else begin
      timer_d = grown;
    end
  end

  assign fire_o = level_i & (press_i | repeat_hit);

  // The timer is written only while the button is held.
  always_ff @(posedge clk_i) begin
    if (advance_i && level_i) begin
      timer_q <= timer_d;
    end
  end

endmodule

>>> src/button_edge_autorepeat.sv
// Top level of the button edge detector with auto-repeat.
// A frame is held in the frame register and its result word in the result register;
// either can stall while out_ready_i is low.
// Throughput: one frame per cycle while the result word is taken without stall; the
// sixteen lane adders and compares sit between the frame register and the result register.
// Reset: configuration registers return to defaults, all buttons count as released, no word
// is pending; hold timers are written at each button's first press.
module button_edge_autorepeat (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bea_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bea_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bea_pkg::out_word_t            out_data_o
);

  logic [15:0] button_enable_q;
  bea_pkg::timing_cfg_t cfg_q;

  logic              s1_valid_q;
  bea_pkg::in_word_t s1_q;
  logic              out_valid_q;
  bea_pkg::out_word_t out_q, out_d;
  logic [15:0]       prev_q;

  logic        advance;
  logic [15:0] tracked, levels, press, release_m, fire;
  logic [bea_pkg::NumLanes-1:0] fire_lanes;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_enable_q   <= bea_pkg::ButtonEnableRst;
      cfg_q.first_delay <= bea_pkg::FirstDelayRst;
      cfg_q.repeat_step <= bea_pkg::RepeatStepRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bea_pkg::RegButtonEnable: button_enable_q   <= cfg_data_i;
        bea_pkg::RegFirstDelay:   cfg_q.first_delay <= cfg_data_i;
        bea_pkg::RegRepeatStep:   cfg_q.repeat_step <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the frame register moves on when the result register is free.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  // Edge masks of the frame in the frame register.
  always_comb begin
    tracked   = button_enable_q & bea_pkg::LaneMask;
    levels    = s1_q.buttons & tracked;
    press     = levels & ~prev_q;
    release_m = prev_q & ~levels & tracked;
  end

  // Per-button timer lanes.
  always_comb begin
    fire = '0;
    fire[bea_pkg::NumLanes-1:0] = fire_lanes;
  end

  for (genvar g = 0; g < bea_pkg::NumLanes; g++) begin : g_lane
    bea_lane u_lane (
      .clk_i      (clk_i),
      .advance_i  (advance),
      .level_i    (levels[g]),
      .press_i    (press[g]),
      .frame_ms_i (s1_q.frame_ms),
      .cfg_i      (cfg_q),
      .fire_o     (fire_lanes[g])
    );
  end

  always_comb begin
    out_d.held         = levels;
    out_d.press_edge   = press;
    out_d.release_edge = release_m;
    out_d.fire         = fire;
  end

  // Control state of both stages and the previous levels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        prev_q      <= levels;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/bea_checker.sv
// Port-level checker for the button block, bound to the top level.
module bea_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bea_pkg::out_word_t out_data_o
);

  // A press edge is always a held button.
  a_press_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.press_edge & ~out_data_o.held) == 16'd0))
    else $error("press edge on a button that is not held");

  // Every press edge fires.
  a_press_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.press_edge & ~out_data_o.fire) == 16'd0))
    else $error("press edge without fire");

  // Only held buttons fire.
  a_fire_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.fire & ~out_data_o.held) == 16'd0))
    else $error("fire on a released button");

  // A released button is not held in the same word.
  a_release_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.release_edge & out_data_o.held) == 16'd0))
    else $error("release edge on a held button");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result word changed while stalled");

endmodule

bind button_edge_autorepeat bea_checker u_bea_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
